// ===== design/afc_pkg.sv =====
// afc_pkg: shared types and constants for the AABB frustum classifier.
// Used by afc_plane and aabb_frustum_classify_core; no dependencies.
package afc_pkg;

   localparam int COORD_BITS  = 24;
   localparam int NUM_PLANES  = 6;
   localparam int NUM_AXES    = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int PLANE_W     = 64;
   localparam int TOL_W       = 24;

   // plane word packing
   localparam int NRM_W   = 12;
   localparam int NX_LSB  = 0;
   localparam int NY_LSB  = 12;
   localparam int NZ_LSB  = 24;
   localparam int OFF_LSB = 36;
   localparam int OFF_W   = 28;
   localparam int OFF_SHIFT = 11;   // offset scaled by 2048

   // doubled centre is one bit wider than a coordinate, doubled extent is
   // non-negative for a valid box and fits a coordinate's width unsigned
   localparam int CTR_W  = COORD_BITS + 1;
   localparam int EXT_W  = COORD_BITS;
   localparam int SPRD_W = NRM_W + CTR_W;   // signed normal x centre
   localparam int RPRD_W = NRM_W + EXT_W;   // |normal| x extent
   localparam int SUM_W  = 48;              // headroom for S+R at the widths above

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_PLANE_LEFT   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PLANE_RIGHT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PLANE_BOTTOM = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PLANE_TOP    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_PLANE_NEAR   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_PLANE_FAR    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_TOLERANCE    = 3'd6;

   typedef enum logic [1:0] {
      CLS_INSIDE    = 2'd0,
      CLS_INTERSECT = 2'd1,
      CLS_OUTSIDE   = 2'd2,
      CLS_INVALID   = 2'd3
   } cls_type;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [CTR_W-1:0]      ctr_type;
   typedef logic        [EXT_W-1:0]      ext_type;
   typedef logic        [PLANE_W-1:0]    plane_type;
   typedef logic        [TOL_W-1:0]      tol_type;

   typedef struct packed {
      logic outside;   // box wholly behind this plane
      logic touch;     // box reaches within tolerance of this plane
   } plane_flags_type;

endpackage

// ===== design/aabb_frustum_classify_core.sv =====
// aabb_frustum_classify_core: box-versus-frustum classifier, top level.
// Path: capture, centre/extent, plane products, then the registered result strobe.
// Throughput: one item per cycle; busy stays low, the four-stage pipe has no stall.
// The receiver cannot stall, so results leave on rsp_valid unconditionally.
// Reset (synchronous, active high) empties the pipe and clears all planes
// and the tolerance to zero. Uses afc_pkg and afc_plane.
module aabb_frustum_classify_core (
   input  logic                               clock,
   input  logic                               reset,
   // item in
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_box_valid,
   input  afc_pkg::coord_type                 req_min_x,
   input  afc_pkg::coord_type                 req_min_y,
   input  afc_pkg::coord_type                 req_min_z,
   input  afc_pkg::coord_type                 req_max_x,
   input  afc_pkg::coord_type                 req_max_y,
   input  afc_pkg::coord_type                 req_max_z,
   // result out
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_classification,
   // register writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [afc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [afc_pkg::PLANE_W-1:0]        csr_wdata
);
   import afc_pkg::*;

   // configuration
   plane_type planes_ff [NUM_PLANES];
   tol_type   tol_ff;

   // stage 1: captured item
   logic      vld1_ff;
   logic      boxok1_ff;
   coord_type lo1_ff [NUM_AXES];
   coord_type hi1_ff [NUM_AXES];

   // stage 2: doubled centre/extent and the invalid check
   logic      vld2_ff;
   logic      bad2_in;
   logic      bad2_ff;
   ctr_type   c2_in [NUM_AXES];
   ctr_type   c2_ff [NUM_AXES];
   ext_type   e2_in [NUM_AXES];
   ext_type   e2_ff [NUM_AXES];

   // stage 3: products live inside the plane units
   logic      vld3_ff;
   logic      bad3_ff;
   plane_flags_type flags [NUM_PLANES];

   // stage 4: result register
   logic      rsp_valid_ff;
   cls_type   cls_in;
   cls_type   cls_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // register file; an index past the tolerance is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NUM_PLANES; p++) begin
            planes_ff[p] <= '0;
         end
         tol_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_PLANE_LEFT:   planes_ff[0] <= csr_wdata;
            REG_PLANE_RIGHT:  planes_ff[1] <= csr_wdata;
            REG_PLANE_BOTTOM: planes_ff[2] <= csr_wdata;
            REG_PLANE_TOP:    planes_ff[3] <= csr_wdata;
            REG_PLANE_NEAR:   planes_ff[4] <= csr_wdata;
            REG_PLANE_FAR:    planes_ff[5] <= csr_wdata;
            REG_TOLERANCE:    tol_ff       <= csr_wdata[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   // pipe control
   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff      <= 1'b0;
         vld2_ff      <= 1'b0;
         vld3_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld1_ff      <= start && !busy;
         vld2_ff      <= vld1_ff;
         vld3_ff      <= vld2_ff;
         rsp_valid_ff <= vld3_ff;
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         boxok1_ff <= req_box_valid;
         lo1_ff[0] <= req_min_x;
         lo1_ff[1] <= req_min_y;
         lo1_ff[2] <= req_min_z;
         hi1_ff[0] <= req_max_x;
         hi1_ff[1] <= req_max_y;
         hi1_ff[2] <= req_max_z;
      end
   end

   // centre and extent, both in doubled units; the extent is only kept
   // meaningful for a well-formed box, so its sign bit is dropped
   always_comb begin
      bad2_in = !boxok1_ff;
      for (int a = 0; a < NUM_AXES; a++) begin
         c2_in[a] = CTR_W'(lo1_ff[a]) + CTR_W'(hi1_ff[a]);
         e2_in[a] = EXT_W'(CTR_W'(hi1_ff[a]) - CTR_W'(lo1_ff[a]));
         if (lo1_ff[a] > hi1_ff[a]) begin
            bad2_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      bad2_ff <= bad2_in;
      c2_ff   <= c2_in;
      e2_ff   <= e2_in;
      bad3_ff <= bad2_ff;
   end

   for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
      afc_plane u_plane (
         .clock (clock),
         .c2    (c2_ff),
         .e2    (e2_ff),
         .plane (planes_ff[p]),
         .tol   (tol_ff),
         .flags (flags[p])
      );
   end

   // an invalid box wins over all; any plane with the box wholly behind it wins over any touch
   always_comb begin
      logic any_out;
      logic any_touch;
      any_out   = 1'b0;
      any_touch = 1'b0;
      for (int p = 0; p < NUM_PLANES; p++) begin
         any_out   = any_out   | flags[p].outside;
         any_touch = any_touch | flags[p].touch;
      end
      if (bad3_ff) begin
         cls_in = CLS_INVALID;
      end else if (any_out) begin
         cls_in = CLS_OUTSIDE;
      end else if (any_touch) begin
         cls_in = CLS_INTERSECT;
      end else begin
         cls_in = CLS_INSIDE;
      end
   end

   always_ff @(posedge clock) begin
      cls_ff <= cls_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_classification = cls_ff;

endmodule

// ===== design/afc_plane.sv =====
// afc_plane: one plane of the frustum test. Registered products of the
// normal with doubled centre and extent, then the S/R compare. Uses afc_pkg.
module afc_plane (
   input  logic                     clock,
   input  afc_pkg::ctr_type         c2 [afc_pkg::NUM_AXES],
   input  afc_pkg::ext_type         e2 [afc_pkg::NUM_AXES],
   input  afc_pkg::plane_type       plane,
   input  afc_pkg::tol_type         tol,
   output afc_pkg::plane_flags_type flags
);
   import afc_pkg::*;

   logic signed [NRM_W-1:0]  nrm [NUM_AXES];
   logic        [NRM_W-1:0]  mag [NUM_AXES];
   logic signed [SPRD_W-1:0] sprd_in [NUM_AXES];
   logic signed [SPRD_W-1:0] sprd_ff [NUM_AXES];
   logic        [RPRD_W-1:0] rprd_in [NUM_AXES];
   logic        [RPRD_W-1:0] rprd_ff [NUM_AXES];
   logic signed [OFF_W-1:0]  offset;
   logic signed [SUM_W-1:0]  sdist;
   logic signed [SUM_W-1:0]  radius;
   logic signed [SUM_W-1:0]  tol_s;

   assign nrm[0] = plane[NX_LSB +: NRM_W];
   assign nrm[1] = plane[NY_LSB +: NRM_W];
   assign nrm[2] = plane[NZ_LSB +: NRM_W];
   assign offset = plane[OFF_LSB +: OFF_W];

   // |-2048| = 2048 still fits twelve bits unsigned
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         mag[a]     = nrm[a][NRM_W-1] ? NRM_W'(-nrm[a]) : nrm[a];
         sprd_in[a] = nrm[a] * c2[a];
         rprd_in[a] = mag[a] * e2[a];
      end
   end

   always_ff @(posedge clock) begin
      sprd_ff <= sprd_in;
      rprd_ff <= rprd_in;
   end

   always_comb begin
      sdist  = (SUM_W'(offset) <<< OFF_SHIFT)
             + SUM_W'(sprd_ff[0]) + SUM_W'(sprd_ff[1]) + SUM_W'(sprd_ff[2]);
      radius = $signed(SUM_W'(rprd_ff[0]) + SUM_W'(rprd_ff[1])
             + SUM_W'(rprd_ff[2]));
      tol_s  = $signed(SUM_W'(tol));
      flags.outside = (sdist + radius) < -tol_s;
      flags.touch   = (sdist - radius) <= tol_s;
   end

endmodule
